[design/violation_escalation_table_macros.svh]
// assertion macros used by the checker file
// no dependencies
`ifndef VIOLATION_ESCALATION_TABLE_MACROS_SVH
`define VIOLATION_ESCALATION_TABLE_MACROS_SVH

// same-cycle implication
`define VET_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("vet assertion failed");

// next-cycle implication
`define VET_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("vet assertion failed");

`endif

[design/vet_pkg.sv]
// shared types and constants of the violation escalation table
// no dependencies
package vet_pkg;

   localparam int SUBJECT_SLOTS = 64;
   localparam int IDX_W = (SUBJECT_SLOTS > 1) ? $clog2(SUBJECT_SLOTS) : 1;
   localparam int CNT_W = IDX_W + 1;
   localparam int ID_W = 16;
   localparam int SCORE_W = 16;
   localparam int MASK_W = 32;
   localparam int ADDR_W = 5;
   localparam int DATA_W = 32;

   typedef enum logic [1:0] {
      OP_VIOLATION = 2'd0,
      OP_QUERY     = 2'd1,
      OP_FORGET    = 2'd2,
      OP_UNUSED    = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      RESP_SUSPICIOUS = 2'd0,
      RESP_QUARANTINE = 2'd1,
      RESP_ISOLATE    = 2'd2,
      RESP_KILL       = 2'd3
   } response_type;

   typedef enum logic [2:0] {
      REG_QUARANTINE_AT   = 3'd0,
      REG_ISOLATE_AT      = 3'd1,
      REG_KILL_AT         = 3'd2,
      REG_QUAR_MASK       = 3'd3,
      REG_ALL_CAPS        = 3'd4
   } reg_index_type;

   localparam logic EVENT_SYSCALL = 1'b0;
   localparam logic EVENT_ABUSE   = 1'b1;

   localparam logic [SCORE_W-1:0] SCORE_MAX = '1;

   localparam logic [SCORE_W-1:0] QUARANTINE_AT_RESET = 16'd3;
   localparam logic [SCORE_W-1:0] ISOLATE_AT_RESET    = 16'd5;
   localparam logic [SCORE_W-1:0] KILL_AT_RESET       = 16'd6;
   localparam logic [MASK_W-1:0]  QUAR_MASK_RESET     = 32'h0000_0000;
   localparam logic [MASK_W-1:0]  ALL_CAPS_RESET      = 32'hFFFF_FFFF;

endpackage

[design/violation_escalation_table.sv]
// violation escalation table: one memory of {owner, score} entries, full scan per item
// one item at a time: req_stall stays high until the current item's result is registered
// each item's scan reads every entry in turn through the single read port
// reset: synchronous; clears all entry valid bits (table empty) and loads register defaults
// depends on vet_pkg
module violation_escalation_table (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  vet_pkg::op_type              req_op,
   input  logic [vet_pkg::ID_W-1:0]     req_proc_id,
   input  logic                         req_kernel_context,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output vet_pkg::response_type        rsp_response,
   output logic [vet_pkg::MASK_W-1:0]   rsp_revoke_mask,
   output logic                         rsp_event_kind,
   output logic [vet_pkg::SCORE_W-1:0]  rsp_score_value,
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [vet_pkg::ADDR_W-1:0]   csr_paddr,
   input  logic [vet_pkg::DATA_W-1:0]   csr_pwdata,
   output logic [vet_pkg::DATA_W-1:0]   csr_prdata,
   output logic                         csr_pready
);
   import vet_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_SCAN   = 3'b010,
      ST_UPDATE = 3'b100
   } state_type;

   // configuration registers
   logic [SCORE_W-1:0] quarantine_at_ff, isolate_at_ff, kill_at_ff;
   logic [MASK_W-1:0]  quar_mask_ff, all_caps_ff;
   reg_index_type      csr_index;
   logic               csr_write;

   // entry memory and valid bits
   logic [ID_W+SCORE_W-1:0] mem [0:SUBJECT_SLOTS-1];
   logic [ID_W+SCORE_W-1:0] rd_data_ff;
   logic [SUBJECT_SLOTS-1:0] valid_ff;
   logic                    mem_we;
   logic [IDX_W-1:0]        wr_addr;
   logic [ID_W+SCORE_W-1:0] wr_data;

   // sequencer
   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   scan_ff, scan_in;
   logic               look_valid_ff, look_valid_in;
   logic               look_live_ff;
   logic [IDX_W-1:0]   look_idx_ff, look_idx_in;
   logic [IDX_W-1:0]   rd_addr;
   logic               scan_done;

   // held item
   op_type             op_ff;
   logic [ID_W-1:0]    id_ff;
   logic               kctx_ff;

   // scan results
   logic               found_ff, found_in;
   logic [IDX_W-1:0]   hit_idx_ff, hit_idx_in;
   logic [SCORE_W-1:0] hit_score_ff, hit_score_in;
   logic               free_found_ff, free_found_in;
   logic [IDX_W-1:0]   free_idx_ff, free_idx_in;
   logic [ID_W-1:0]    look_owner;
   logic [SCORE_W-1:0] look_score;

   // result
   logic               update_fire;
   logic               accept;
   logic               rsp_valid_ff, rsp_valid_in;
   response_type       resp_ff, resp_in;
   logic [MASK_W-1:0]  mask_ff, mask_in;
   logic               kind_ff, kind_in;
   logic [SCORE_W-1:0] score_ff, score_in;
   logic [SCORE_W-1:0] base_score, new_score;
   logic [IDX_W-1:0]   slot_sel;
   logic               slot_ok;
   logic               clear_we;

   // configuration port
   assign csr_pready = 1'b1;
   assign csr_index  = reg_index_type'(csr_paddr[ADDR_W-1:2]);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      unique case (csr_index)
         REG_QUARANTINE_AT:   csr_prdata = DATA_W'(quarantine_at_ff);
         REG_ISOLATE_AT:      csr_prdata = DATA_W'(isolate_at_ff);
         REG_KILL_AT:         csr_prdata = DATA_W'(kill_at_ff);
         REG_QUAR_MASK:       csr_prdata = quar_mask_ff;
         REG_ALL_CAPS:        csr_prdata = all_caps_ff;
         default:             csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         quarantine_at_ff   <= QUARANTINE_AT_RESET;
         isolate_at_ff      <= ISOLATE_AT_RESET;
         kill_at_ff         <= KILL_AT_RESET;
         quar_mask_ff       <= QUAR_MASK_RESET;
         all_caps_ff        <= ALL_CAPS_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_QUARANTINE_AT:   quarantine_at_ff   <= csr_pwdata[SCORE_W-1:0];
            REG_ISOLATE_AT:      isolate_at_ff      <= csr_pwdata[SCORE_W-1:0];
            REG_KILL_AT:         kill_at_ff         <= csr_pwdata[SCORE_W-1:0];
            REG_QUAR_MASK:       quar_mask_ff       <= csr_pwdata[MASK_W-1:0];
            REG_ALL_CAPS:        all_caps_ff        <= csr_pwdata[MASK_W-1:0];
            default: ;
         endcase
      end
   end

   // handshakes
   assign req_stall   = (state_ff != ST_IDLE);
   assign accept      = req_valid && !req_stall;
   assign update_fire = (state_ff == ST_UPDATE) && (!rsp_valid_ff || !rsp_stall);

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_response    = resp_ff;
   assign rsp_revoke_mask = mask_ff;
   assign rsp_event_kind  = kind_ff;
   assign rsp_score_value = score_ff;

   // scan
   assign scan_done = (scan_ff == CNT_W'(SUBJECT_SLOTS));
   assign rd_addr   = scan_ff[IDX_W-1:0];
   assign look_owner = look_live_ff ? rd_data_ff[ID_W+SCORE_W-1:SCORE_W] : '0;
   assign look_score = look_live_ff ? rd_data_ff[SCORE_W-1:0] : '0;

   always_comb begin
      state_in      = state_ff;
      scan_in       = scan_ff;
      look_valid_in = 1'b0;
      look_idx_in   = look_idx_ff;
      found_in      = found_ff;
      hit_idx_in    = hit_idx_ff;
      hit_score_in  = hit_score_ff;
      free_found_in = free_found_ff;
      free_idx_in   = free_idx_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in      = ST_SCAN;
               scan_in       = '0;
               found_in      = 1'b0;
               free_found_in = 1'b0;
            end
         end
         ST_SCAN: begin
            if (!scan_done) begin
               look_valid_in = 1'b1;
               look_idx_in   = rd_addr;
               scan_in       = scan_ff + CNT_W'(1);
            end
            if (look_valid_ff) begin
               if (!found_ff && id_ff != '0 && look_owner == id_ff) begin
                  found_in     = 1'b1;
                  hit_idx_in   = look_idx_ff;
                  hit_score_in = look_score;
               end
               if (!free_found_ff && look_owner == '0) begin
                  free_found_in = 1'b1;
                  free_idx_in   = look_idx_ff;
               end
            end
            if (scan_done && !look_valid_ff) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            if (update_fire) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // result and entry update: read-modify-write on a violation, valid-bit clear on forget
   always_comb begin
      slot_ok    = found_ff || (id_ff != '0 && free_found_ff);
      slot_sel   = found_ff ? hit_idx_ff : free_idx_ff;
      base_score = found_ff ? hit_score_ff : '0;
      new_score  = (base_score == SCORE_MAX) ? base_score : base_score + SCORE_W'(1);
      resp_in    = RESP_SUSPICIOUS;
      mask_in    = '0;
      kind_in    = EVENT_SYSCALL;
      score_in   = '0;
      mem_we     = 1'b0;
      clear_we   = 1'b0;
      wr_addr    = slot_sel;
      wr_data    = {id_ff, new_score};
      unique case (op_ff)
         OP_VIOLATION: begin
            if (!kctx_ff) begin
               if (!slot_ok) begin
                  resp_in = RESP_ISOLATE;
                  mask_in = all_caps_ff;
                  kind_in = EVENT_ABUSE;
               end else begin
                  mem_we   = update_fire;
                  score_in = new_score;
                  priority if (new_score >= kill_at_ff) resp_in = RESP_KILL;
                  else if (new_score >= isolate_at_ff) resp_in = RESP_ISOLATE;
                  else if (new_score >= quarantine_at_ff) resp_in = RESP_QUARANTINE;
                  else resp_in = RESP_SUSPICIOUS;
                  unique case (resp_in)
                     RESP_QUARANTINE:       mask_in = quar_mask_ff;
                     RESP_ISOLATE, RESP_KILL: mask_in = all_caps_ff;
                     default:               mask_in = '0;
                  endcase
               end
            end
         end
         OP_QUERY: begin
            score_in = found_ff ? hit_score_ff : '0;
         end
         OP_FORGET: begin
            clear_we = update_fire && found_ff;
            wr_addr  = hit_idx_ff;
         end
         default: ;
      endcase
      rsp_valid_in = update_fire || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         scan_ff       <= '0;
         look_valid_ff <= 1'b0;
         look_live_ff  <= 1'b0;
         valid_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
         found_ff      <= 1'b0;
         free_found_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         scan_ff       <= scan_in;
         look_valid_ff <= look_valid_in;
         look_live_ff  <= valid_ff[rd_addr];
         rsp_valid_ff  <= rsp_valid_in;
         found_ff      <= found_in;
         free_found_ff <= free_found_in;
         if (mem_we) begin
            valid_ff[wr_addr] <= 1'b1;
         end else if (clear_we) begin
            valid_ff[wr_addr] <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      look_idx_ff  <= look_idx_in;
      hit_idx_ff   <= hit_idx_in;
      hit_score_ff <= hit_score_in;
      free_idx_ff  <= free_idx_in;
      if (accept) begin
         op_ff   <= req_op;
         id_ff   <= req_proc_id;
         kctx_ff <= req_kernel_context;
      end
      if (update_fire) begin
         resp_ff  <= resp_in;
         mask_ff  <= mask_in;
         kind_ff  <= kind_in;
         score_ff <= score_in;
      end
   end

endmodule

[design/vet_checker.sv]
// port-level checks of the violation escalation table, bound to the top level
// depends on vet_pkg and violation_escalation_table_macros.svh
`include "violation_escalation_table_macros.svh"

module vet_props (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_stall,
   input logic                         rsp_valid,
   input logic                         rsp_stall,
   input vet_pkg::response_type        rsp_response,
   input logic [vet_pkg::MASK_W-1:0]   rsp_revoke_mask,
   input logic                         rsp_event_kind,
   input logic [vet_pkg::SCORE_W-1:0]  rsp_score_value
);
   import vet_pkg::*;

   `VET_ASSERT_NEXT(busy_after_accept, clock, reset, req_valid && !req_stall, req_stall)

   `VET_ASSERT_NEXT(rsp_holds, clock, reset, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_response) && $stable(rsp_revoke_mask)
      && $stable(rsp_event_kind) && $stable(rsp_score_value))

   `VET_ASSERT_SAME(abuse_is_isolate, clock, reset, rsp_valid && rsp_event_kind == EVENT_ABUSE,
      rsp_response == RESP_ISOLATE && rsp_score_value == '0)

   `VET_ASSERT_SAME(suspicious_no_mask, clock, reset,
      rsp_valid && rsp_response == RESP_SUSPICIOUS, rsp_revoke_mask == '0)

endmodule

bind violation_escalation_table vet_props u_vet_props (.*);
